@@ src/jsee_pkg.sv @@
// Package for the JSON string escape encoder: job record, job kinds,
// character constants and small helper functions.
// No dependencies.
package jsee_pkg;

  localparam int unsigned QueueDepthDefault = 4;
  localparam int unsigned SeqBytesMax       = 4;

  localparam logic [16:0] BufferSizeReset = 17'd256;

  localparam logic [7:0] CharBackslash = 8'h5C;
  localparam logic [7:0] CharQuote     = 8'h22;
  localparam logic [7:0] CharLowerB    = 8'h62;
  localparam logic [7:0] CharLowerT    = 8'h74;
  localparam logic [7:0] CharLowerN    = 8'h6E;
  localparam logic [7:0] CharLowerF    = 8'h66;
  localparam logic [7:0] CharLowerR    = 8'h72;
  localparam logic [7:0] CharLowerU    = 8'h75;
  localparam logic [7:0] CharZero      = 8'h30;
  localparam logic [7:0] CharUpperA    = 8'h41;

  localparam logic [7:0] CtrlBackspace = 8'h08;
  localparam logic [7:0] CtrlTab       = 8'h09;
  localparam logic [7:0] CtrlNewline   = 8'h0A;
  localparam logic [7:0] CtrlFormfeed  = 8'h0C;
  localparam logic [7:0] CtrlReturn    = 8'h0D;
  localparam logic [7:0] CtrlMax       = 8'h1F;
  localparam logic [7:0] AsciiMax      = 8'h7F;

  localparam logic [7:0] Lead2Mask = 8'hE0;
  localparam logic [7:0] Lead2Code = 8'hC0;
  localparam logic [7:0] Lead3Mask = 8'hF0;
  localparam logic [7:0] Lead3Code = 8'hE0;
  localparam logic [7:0] Lead4Mask = 8'hF8;
  localparam logic [7:0] Lead4Code = 8'hF0;

  typedef enum logic [2:0] {
    JobPass,
    JobEsc,
    JobUni,
    JobSeq,
    JobOvf,
    JobTerm
  } job_kind_t;

  typedef struct packed {
    job_kind_t                 kind;
    logic [2:0]                count;   // output bytes, 1 to 6
    logic [SeqBytesMax-1:0][7:0] data;
    logic [15:0]               length;
  } job_t;

  // Uppercase hex digit of a nibble
  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] r;
    if (nib < 4'd10) r = CharZero + {4'd0, nib};
    else             r = CharUpperA + {4'd0, nib} - 8'd10;
    return r;
  endfunction

  // Usable bytes of a buffer, terminator slot excluded, clamped to 16 bits
  function automatic logic [15:0] capacity(input logic [16:0] size);
    logic [15:0] r;
    if (size == 17'd0)  r = 16'd0;
    else if (size[16])  r = 16'hFFFF;
    else                r = size[15:0] - 16'd1;
    return r;
  endfunction

endpackage

@@ src/jsee_queue.sv @@
// Short job queue between the front and back parts of the escape encoder.
// Depends on jsee_pkg for job_t.
module jsee_queue
  import jsee_pkg::*;
#(
  parameter int unsigned DEPTH = QueueDepthDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output job_t head_job
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  job_t            slots [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] fill;

  assign full       = (fill == CntW'(DEPTH));
  assign head_valid = (fill != '0);
  assign head_job   = slots[rd_ptr];

  function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    if (p == PtrW'(DEPTH - 1)) r = '0;
    else                       r = p + PtrW'(1);
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= bump(wr_ptr);
      if (pop)  rd_ptr <= bump(rd_ptr);
      unique case ({push, pop})
        2'b10:   fill <= fill + CntW'(1);
        2'b01:   fill <= fill - CntW'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

@@ src/jsee_front.sv @@
// Front part of the escape encoder: accepts raw bytes, tracks buffer space,
// UTF-8 sequences and abort state, and turns each byte into at most one job.
// Depends on jsee_pkg.
module jsee_front
  import jsee_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [16:0] cfg_wr_data,
  input  logic        accept,
  input  logic [7:0]  in_byte,
  output logic        push,
  output job_t        push_job
);

  logic [15:0]     cap;
  logic [15:0]     space_left;
  logic [2:0][7:0] held_bytes;
  logic [1:0]      bytes_needed;
  logic [1:0]      bytes_held;
  logic            aborted;

  logic [15:0] space_left_next;
  logic [1:0]  bytes_needed_next;
  logic [1:0]  bytes_held_next;
  logic        aborted_next;
  logic        hold_wr;
  logic [7:0]  esc;
  logic [2:0]  need;
  logic [15:0] cap_cfg;

  assign cap_cfg = capacity(cfg_wr_data);

  always_comb begin
    unique case (in_byte)
      CtrlBackspace: esc = CharLowerB;
      CtrlTab:       esc = CharLowerT;
      CtrlNewline:   esc = CharLowerN;
      CtrlFormfeed:  esc = CharLowerF;
      CtrlReturn:    esc = CharLowerR;
      CharQuote:     esc = CharQuote;
      CharBackslash: esc = CharBackslash;
      default:       esc = 8'd0;
    endcase
  end

  always_comb begin
    push              = 1'b0;
    push_job          = '0;
    push_job.data[0]  = in_byte;
    space_left_next   = space_left;
    bytes_needed_next = bytes_needed;
    bytes_held_next   = bytes_held;
    aborted_next      = aborted;
    hold_wr           = 1'b0;
    need              = 3'd0;

    if (accept) begin
      if (in_byte == 8'd0) begin
        // terminator: report length unless aborted, then restart the string
        push              = !aborted;
        push_job.kind     = JobTerm;
        push_job.count    = 3'd1;
        push_job.data[0]  = 8'd0;
        push_job.length   = cap - space_left;
        space_left_next   = cap;
        bytes_needed_next = 2'd0;
        bytes_held_next   = 2'd0;
        aborted_next      = 1'b0;
      end else if (aborted) begin
        // drop until terminator
      end else if (bytes_needed != 2'd0) begin
        if (bytes_needed == 2'd1) begin
          push                      = 1'b1;
          push_job.kind             = JobSeq;
          push_job.count            = {1'b0, bytes_held} + 3'd1;
          push_job.data[2:0]        = held_bytes;
          push_job.data[3]          = 8'd0;
          push_job.data[bytes_held] = in_byte;
          space_left_next   = space_left - {13'd0, push_job.count};
          bytes_needed_next = 2'd0;
          bytes_held_next   = 2'd0;
        end else begin
          hold_wr           = 1'b1;
          bytes_held_next   = bytes_held + 2'd1;
          bytes_needed_next = bytes_needed - 2'd1;
        end
      end else begin
        if (esc != 8'd0) begin
          need             = 3'd2;
          push_job.kind    = JobEsc;
          push_job.data[0] = esc;
        end else if (in_byte <= CtrlMax) begin
          need          = 3'd6;
          push_job.kind = JobUni;
        end else if (in_byte <= AsciiMax) begin
          need          = 3'd1;
          push_job.kind = JobPass;
        end else if ((in_byte & Lead2Mask) == Lead2Code) begin
          need          = 3'd2;
          push_job.kind = JobSeq;
        end else if ((in_byte & Lead3Mask) == Lead3Code) begin
          need          = 3'd3;
          push_job.kind = JobSeq;
        end else if ((in_byte & Lead4Mask) == Lead4Code) begin
          need          = 3'd4;
          push_job.kind = JobSeq;
        end

        if (need != 3'd0) begin
          if (space_left < {13'd0, need}) begin
            push             = 1'b1;
            push_job.kind    = JobOvf;
            push_job.count   = 3'd1;
            push_job.data[0] = 8'd0;
            aborted_next     = 1'b1;
          end else if (push_job.kind == JobSeq) begin
            // lead byte: hold it, space is taken when the sequence completes
            hold_wr           = 1'b1;
            bytes_held_next   = 2'd1;
            bytes_needed_next = 2'(need - 3'd1);
          end else begin
            push            = 1'b1;
            push_job.count  = need;
            space_left_next = space_left - {13'd0, need};
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hold_wr) begin
      held_bytes[bytes_held] <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap          <= capacity(BufferSizeReset);
      space_left   <= capacity(BufferSizeReset);
      bytes_needed <= 2'd0;
      bytes_held   <= 2'd0;
      aborted      <= 1'b0;
    end else if (cfg_wr_en) begin
      cap          <= cap_cfg;
      space_left   <= cap_cfg;
      bytes_needed <= 2'd0;
      bytes_held   <= 2'd0;
      aborted      <= 1'b0;
    end else begin
      space_left   <= space_left_next;
      bytes_needed <= bytes_needed_next;
      bytes_held   <= bytes_held_next;
      aborted      <= aborted_next;
    end
  end

endmodule

@@ src/jsee_back.sv @@
// Back part of the escape encoder: expands the job at the queue head into
// output bytes, one per unstalled cycle, into a registered output stage.
// Depends on jsee_pkg.
module jsee_back
  import jsee_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        head_valid,
  input  job_t        head_job,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        last_of_run,
  output logic        done_res,
  output logic        overflow,
  output logic [15:0] out_length
);

  logic [2:0] idx;
  logic       advance;
  logic       at_last;
  logic [7:0] byte_sel;

  assign advance = head_valid && (!out_valid || !out_stall);
  assign at_last = (idx == head_job.count - 3'd1);
  assign pop     = advance && at_last;

  always_comb begin
    byte_sel = 8'd0;
    unique case (head_job.kind)
      JobPass: byte_sel = head_job.data[0];
      JobEsc:  byte_sel = (idx == 3'd0) ? CharBackslash : head_job.data[0];
      JobUni: begin
        unique case (idx)
          3'd0:    byte_sel = CharBackslash;
          3'd1:    byte_sel = CharLowerU;
          3'd2:    byte_sel = CharZero;
          3'd3:    byte_sel = CharZero;
          3'd4:    byte_sel = hex_digit(head_job.data[0][7:4]);
          default: byte_sel = hex_digit(head_job.data[0][3:0]);
        endcase
      end
      JobSeq:  byte_sel = head_job.data[idx[1:0]];
      JobOvf:  byte_sel = 8'd0;
      JobTerm: byte_sel = 8'd0;
      default: byte_sel = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte    <= byte_sel;
      last_of_run <= at_last;
      done_res    <= (head_job.kind == JobTerm);
      overflow    <= (head_job.kind == JobOvf);
      out_length  <= (head_job.kind == JobTerm) ? head_job.length : 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 3'd0;
    end else begin
      if (advance)           out_valid <= 1'b1;
      else if (!out_stall)   out_valid <= 1'b0;
      if (pop)               idx <= 3'd0;
      else if (advance)      idx <= idx + 3'd1;
    end
  end

endmodule

@@ src/json_string_escape_encoder_unit.sv @@
// JSON string escape encoder, top level.
// Instantiates jsee_front, jsee_queue and jsee_back; depends on jsee_pkg.
//
// Usage
//   Input channel in_valid / in_stall / in_byte carries one raw string byte
//   per request; a zero byte ends the string. Output channel out_valid /
//   out_stall carries one escaped byte per request with last_of_run,
//   done_res, overflow and out_length (length valid with done_res only).
//   cfg_wr_en / cfg_wr_data set buffer_size; write only while the block is
//   idle. A write also restarts the current string.
//   out_valid rises after the request is accepted: the front classifies and
//   queues it, then the back part registers the byte. Throughput: one input
//   byte per cycle when it yields at most one output byte and out_stall is
//   low; otherwise the back part emits one output byte per unstalled cycle
//   (up to six for a \u00XX escape), set by the single expansion counter.
//   Reset (synchronous, rst high) empties the queue, clears the output stage,
//   sets buffer_size to 256 and restarts the string state.
//   A stalled output holds its byte; the back part waits, the queue fills and
//   in_stall rises once the queue is full. Bytes that give no result
//   (dropped or held) are still taken by the front without queuing a job.
module json_string_escape_encoder_unit
  import jsee_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [16:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        last_of_run,
  output logic        done_res,
  output logic        overflow,
  output logic [15:0] out_length
);

  logic accept;
  logic q_full;
  logic push;
  job_t push_job;
  logic pop;
  logic head_valid;
  job_t head_job;

  // stall the source while the queue has no room for a job
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  jsee_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .accept      (accept),
    .in_byte     (in_byte),
    .push        (push),
    .push_job    (push_job)
  );

  jsee_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  jsee_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head_job    (head_job),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .last_of_run (last_of_run),
    .done_res    (done_res),
    .overflow    (overflow),
    .out_length  (out_length)
  );

endmodule
